// ===== design/prbr_pkg.sv =====
// Shared types and constants of the packed bitmap row-align repacker.
package prbr_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ROW_W = 8;
  localparam int unsigned BIR_W = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 1'b1;

  localparam logic [BYTE_W-1:0] GLYPH_WIDTH_RST = 8'd8;
  localparam logic [BYTE_W-1:0] GLYPH_HEIGHT_RST = 8'd8;

  // Head of the queue as seen by the back end.
  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
  } q_head_t;

endpackage

// ===== design/packed_bitmap_row_align_repacker.sv =====
// Top level of the packed bitmap row-align repacker with its configuration registers.
//
// Source bytes of a 1bpp glyph, pixels packed back to back MSB first, enter on the
// in_ channel (valid/ready) and leave re-packed row by row on the out_ channel: every
// row starts a new byte, unused low bits of a row's last byte are zero. Each output
// item carries its row, its byte position in the row, a glyph-done flag on the final
// byte of the glyph and a flag on the last output item caused by each source byte.
// Glyph width and height are written through the cfg_ port (index 0 and 1, a value of
// zero acts as one) and must only be changed while the block is idle.
// A source byte passes an input register and a short queue, then the repacking engine
// produces one output item per cycle while the receiver takes them; a byte reaches
// out_valid via the input register, queue and output register. A source byte
// yields one to eight output items; with glyphs at least eight pixels wide a new byte
// is usually taken every cycle, narrow glyphs are limited by the one-item-per-cycle
// output register. When the receiver stalls, the output register holds its item, the
// engine stops and the queue and input slot fill before in_ready drops.
// Synchronous reset empties the pipeline, restarts the glyph at row 0, column 0 with
// no pending bits, and sets both dimensions to eight.
module packed_bitmap_row_align_repacker #(
  parameter int unsigned QUEUE_DEPTH = prbr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [prbr_pkg::BYTE_W-1:0]      in_src_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [prbr_pkg::BYTE_W-1:0]      out_dst_byte,
  output logic [prbr_pkg::ROW_W-1:0]       out_row_number,
  output logic [prbr_pkg::BIR_W-1:0]       out_byte_in_row,
  output logic                             out_glyph_done,
  output logic                             out_last_of_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [prbr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [prbr_pkg::BYTE_W-1:0]      cfg_wdata
);
  import prbr_pkg::*;

  logic [BYTE_W-1:0] glyph_width_r, glyph_width_nxt;
  logic [BYTE_W-1:0] glyph_height_r, glyph_height_nxt;
  logic              q_full;
  logic              q_push;
  logic [BYTE_W-1:0] q_push_data;
  logic              q_pop;
  q_head_t           q_head;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_comb begin
    glyph_width_nxt  = glyph_width_r;
    glyph_height_nxt = glyph_height_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_GLYPH_WIDTH:  glyph_width_nxt = cfg_wdata;
        REG_GLYPH_HEIGHT: glyph_height_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_width_r  <= GLYPH_WIDTH_RST;
      glyph_height_r <= GLYPH_HEIGHT_RST;
    end else begin
      glyph_width_r  <= glyph_width_nxt;
      glyph_height_r <= glyph_height_nxt;
    end
  end

  // The front takes source bytes into a register slice and hands them to the queue.
  prbr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_src_byte (in_src_byte),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  prbr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head)
  );

  // The back end releases a queue entry on the cycle it registers that byte's last item.
  prbr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (q_head),
    .pop              (q_pop),
    .glyph_width      (glyph_width_r),
    .glyph_height     (glyph_height_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_dst_byte     (out_dst_byte),
    .out_row_number   (out_row_number),
    .out_byte_in_row  (out_byte_in_row),
    .out_glyph_done   (out_glyph_done),
    .out_last_of_item (out_last_of_item)
  );

`ifndef NO_ASSERTIONS
  // An entry is only released while the queue holds one.
  a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_head.valid)
    else $error("queue popped while empty");

  // The final byte of a glyph always ends the work of its source byte.
  a_done_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_glyph_done) |-> out_last_of_item)
    else $error("glyph finished before its source byte was released");

  // Reset leaves no item on the output.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");
`endif

endmodule

// ===== design/prbr_front.sv =====
// Input register slice of the repacker: takes source bytes and feeds the queue.
module prbr_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [prbr_pkg::BYTE_W-1:0] in_src_byte,
  input  logic                       q_full,
  output logic                       q_push,
  output logic [prbr_pkg::BYTE_W-1:0] q_push_data
);
  import prbr_pkg::*;

  logic              slot_valid_r, slot_valid_nxt;
  logic [BYTE_W-1:0] slot_byte_r, slot_byte_nxt;

  always_comb begin
    q_push         = slot_valid_r && !q_full;
    in_ready       = !slot_valid_r || !q_full;
    slot_valid_nxt = slot_valid_r;
    slot_byte_nxt  = slot_byte_r;
    if (in_valid && in_ready) begin
      slot_valid_nxt = 1'b1;
      slot_byte_nxt  = in_src_byte;
    end else if (q_push) begin
      slot_valid_nxt = 1'b0;
    end
  end

  assign q_push_data = slot_byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= 1'b0;
    end else begin
      slot_valid_r <= slot_valid_nxt;
    end
    slot_byte_r <= slot_byte_nxt;
  end

endmodule

// ===== design/prbr_queue.sv =====
// Short queue of source bytes between the front and the back end.
module prbr_queue #(
  parameter int unsigned DEPTH = prbr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic [prbr_pkg::BYTE_W-1:0] push_data,
  output logic                        full,
  input  logic                        pop,
  output prbr_pkg::q_head_t           head
);
  import prbr_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [BYTE_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head.valid = (count_r != '0);
  assign head.data  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== design/prbr_back.sv =====
// Repacking engine: cuts source bytes into row-aligned bytes, one per unstalled cycle.
module prbr_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  prbr_pkg::q_head_t            head,
  output logic                         pop,
  input  logic [prbr_pkg::BYTE_W-1:0]  glyph_width,
  input  logic [prbr_pkg::BYTE_W-1:0]  glyph_height,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [prbr_pkg::BYTE_W-1:0]  out_dst_byte,
  output logic [prbr_pkg::ROW_W-1:0]   out_row_number,
  output logic [prbr_pkg::BIR_W-1:0]   out_byte_in_row,
  output logic                         out_glyph_done,
  output logic                         out_last_of_item
);
  import prbr_pkg::*;

  // Pending bits are kept left-justified; pc_r counts them.
  logic [BYTE_W-1:0] acc_r, acc_nxt;
  logic [2:0]        pc_r, pc_nxt;
  logic [2:0]        pos_r, pos_nxt;
  logic [7:0]        col_r, col_nxt;
  logic [7:0]        row_r, row_nxt;

  logic              ov_r, ov_nxt;
  logic [BYTE_W-1:0] dst_r, dst_nxt;
  logic [ROW_W-1:0]  rown_r, rown_nxt;
  logic [BIR_W-1:0]  bir_r, bir_nxt;
  logic              done_r, done_nxt;
  logic              last_r, last_nxt;

  logic       step;
  logic [7:0] w_eff, h_eff;
  logic [8:0] w9, col_p1, dr, row_p1, col_a_p1, dr2;
  logic [3:0] df, k, pos_sum, rem;
  logic       row_end, glyph_end, more;
  logic [7:0] shifted, take, rest, col_end, col_ev, col_a;

  always_comb begin
    step  = head.valid && (!ov_r || out_ready);
    w_eff = (glyph_width == '0) ? 8'd1 : glyph_width;
    h_eff = (glyph_height == '0) ? 8'd1 : glyph_height;
    w9    = {1'b0, w_eff};

    // Bits until the row ends and until the output byte fills.
    col_p1  = {1'b0, col_r} + 9'd1;
    dr      = (col_p1 >= w9) ? 9'd1 : (w9 - {1'b0, col_r});
    df      = 4'd8 - {1'b0, pc_r};
    row_end = (dr <= {5'd0, df});
    k       = row_end ? dr[3:0] : df;

    shifted = head.data << pos_r;
    take    = shifted & ~(8'hFF >> k);
    rest    = shifted << k;
    col_end = col_r + {4'd0, k};
    col_ev  = col_end - 8'd1;

    row_p1    = {1'b0, row_r} + 9'd1;
    glyph_end = row_end && (row_p1 >= {1'b0, h_eff});

    // Does a further output fall inside what is left of this byte?
    pos_sum  = {1'b0, pos_r} + k;
    rem      = 4'd8 - pos_sum;
    col_a    = row_end ? 8'd0 : col_end;
    col_a_p1 = {1'b0, col_a} + 9'd1;
    dr2      = (col_a_p1 >= w9) ? 9'd1 : (w9 - {1'b0, col_a});
    more     = !glyph_end && (dr2 <= {5'd0, rem});

    pop = step && !more;

    acc_nxt  = acc_r;
    pc_nxt   = pc_r;
    pos_nxt  = pos_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    ov_nxt   = ov_r && !out_ready;
    dst_nxt  = dst_r;
    rown_nxt = rown_r;
    bir_nxt  = bir_r;
    done_nxt = done_r;
    last_nxt = last_r;

    if (step) begin
      ov_nxt   = 1'b1;
      dst_nxt  = acc_r | (take >> pc_r);
      rown_nxt = row_r;
      bir_nxt  = col_ev[7:3];
      done_nxt = glyph_end;
      last_nxt = !more;
      if (glyph_end) begin
        row_nxt = '0;
      end else if (row_end) begin
        row_nxt = row_p1[7:0];
      end
      if (more) begin
        acc_nxt = '0;
        pc_nxt  = '0;
        col_nxt = col_a;
        pos_nxt = pos_sum[2:0];
      end else if (glyph_end) begin
        // Padding bits after the last pixel are dropped.
        acc_nxt = '0;
        pc_nxt  = '0;
        col_nxt = '0;
        pos_nxt = '0;
      end else begin
        acc_nxt = rest;
        pc_nxt  = rem[2:0];
        col_nxt = col_a + {4'd0, rem};
        pos_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      pc_r   <= '0;
      pos_r  <= '0;
      col_r  <= '0;
      row_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      pc_r   <= pc_nxt;
      pos_r  <= pos_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      ov_r   <= ov_nxt;
    end
    dst_r  <= dst_nxt;
    rown_r <= rown_nxt;
    bir_r  <= bir_nxt;
    done_r <= done_nxt;
    last_r <= last_nxt;
  end

  assign out_valid        = ov_r;
  assign out_dst_byte     = dst_r;
  assign out_row_number   = rown_r;
  assign out_byte_in_row  = bir_r;
  assign out_glyph_done   = done_r;
  assign out_last_of_item = last_r;

endmodule
